// ===== hw/rtl/lcm_pkg.sv =====
// Shared types and constants for the log counter merge block.
`timescale 1ns / 1ps
`default_nettype none
package lcm_pkg;

    localparam int CELL_W  = 15;
    localparam int MANT_W  = 10;
    localparam int EXP_W   = 5;
    localparam int CNT_W   = 42;
    localparam int EX_W    = 6;
    localparam int OUT_W   = 16;
    localparam int HASH_W  = 32;

    localparam logic [CELL_W-1:0] CellLinMax = CELL_W'(2048);
    localparam logic [CNT_W-1:0]  CntLinMax  = CNT_W'(2048);

    localparam logic [31:0] MurC1   = 32'hcc9e2d51;
    localparam logic [31:0] MurC2   = 32'h1b873593;
    localparam logic [31:0] MurAdd  = 32'he6546b64;
    localparam logic [31:0] MurF1   = 32'h85ebca6b;
    localparam logic [31:0] MurF2   = 32'hc2b2ae35;
    localparam logic [31:0] MurLen  = 32'd8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_BLK_LO,
        OP_BLK_HI,
        OP_ROT,
        OP_MIX,
        OP_FM1,
        OP_FM2,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLK_LO,
        S_ROT_LO,
        S_MIX_LO,
        S_BLK_HI,
        S_ROT_HI,
        S_MIX_HI,
        S_FM1,
        S_FM2,
        S_WAIT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
    } t_stat;

endpackage
`default_nettype wire

// ===== hw/rtl/lcm_ctrl.sv =====
// Sequencer for the merge: handshakes and hash/normalize step control.
`timescale 1ns / 1ps
`default_nettype none
module lcm_ctrl
    import lcm_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  wire   i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ovalid   = r_ovalid && !i_out_ready;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_BLK_LO;
                end
            end
            S_BLK_LO: begin
                o_cmd.op = OP_BLK_LO;
                n_state  = S_ROT_LO;
            end
            S_ROT_LO: begin
                o_cmd.op = OP_ROT;
                n_state  = S_MIX_LO;
            end
            S_MIX_LO: begin
                o_cmd.op = OP_MIX;
                n_state  = S_BLK_HI;
            end
            S_BLK_HI: begin
                o_cmd.op = OP_BLK_HI;
                n_state  = S_ROT_HI;
            end
            S_ROT_HI: begin
                o_cmd.op = OP_ROT;
                n_state  = S_MIX_HI;
            end
            S_MIX_HI: begin
                o_cmd.op = OP_MIX;
                n_state  = S_FM1;
            end
            S_FM1: begin
                o_cmd.op = OP_FM1;
                n_state  = S_FM2;
            end
            S_FM2: begin
                o_cmd.op = OP_FM2;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                // hold until the shifter is done and the output slot is free
                if (i_stat.norm_done && (!r_ovalid || i_out_ready)) begin
                    o_cmd.op = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

// ===== hw/rtl/lcm_dpath.sv =====
// Datapath: cell decode, sum, serial normalizer, shared hash multiplier.
`timescale 1ns / 1ps
`default_nettype none
module lcm_dpath
    import lcm_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [31:0]       i_cfg_wdata,
    input  wire  [CELL_W-1:0] i_first_cell,
    input  wire  [CELL_W-1:0] i_second_cell,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic [OUT_W-1:0]  o_merged_cell
);

    logic [31:0]       r_seed;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [CNT_W-1:0]  r_top;
    logic [EX_W-1:0]   r_ex;
    logic [31:0]       r_mask;
    logic [HASH_W-1:0] r_acc, n_acc;
    logic [HASH_W-1:0] r_blk, n_blk;
    logic [OUT_W-1:0]  r_out, n_out;

    function automatic logic [CNT_W-1:0] cell_count(input logic [CELL_W-1:0] cval);
        logic [EXP_W-1:0] sh;
        if (cval <= CellLinMax) begin
            cell_count = CNT_W'(cval);
        end else begin
            sh = cval[CELL_W-1:MANT_W] - EXP_W'(1);
            cell_count = CNT_W'({1'b1, cval[MANT_W-1:0]}) << sh;
        end
    endfunction

    logic              norm_busy;
    logic [31:0]       mul_a, mul_b;
    logic [31:0]       prod;
    logic [31:0]       mix_t, fin_a, fin_b, hv, frac;
    logic              inc;

    assign norm_busy = (r_top[CNT_W-1:11] != '0);
    assign o_stat.norm_done = !norm_busy;

    assign mix_t = r_acc ^ r_blk;
    assign fin_a = r_acc ^ MurLen;
    assign fin_b = fin_a ^ (fin_a >> 16);
    assign hv    = r_acc ^ (r_acc >> 16);
    assign frac  = r_total[31:0] & r_mask;
    assign inc   = (hv & r_mask) < frac;

    // one shared 32x32 multiplier, operands picked by the current step
    always_comb begin
        mul_a = r_blk;
        mul_b = MurC1;
        case (i_cmd.op)
            OP_BLK_LO: begin
                mul_a = r_total[31:0];
                mul_b = MurC1;
            end
            OP_BLK_HI: begin
                mul_a = 32'(r_total[CNT_W-1:32]);
                mul_b = MurC1;
            end
            OP_ROT: begin
                mul_a = {r_blk[16:0], r_blk[31:17]};
                mul_b = MurC2;
            end
            OP_FM1: begin
                mul_a = fin_b;
                mul_b = MurF1;
            end
            OP_FM2: begin
                mul_a = r_acc ^ (r_acc >> 13);
                mul_b = MurF2;
            end
            default: begin
                mul_a = r_blk;
                mul_b = MurC1;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_comb begin
        n_total = r_total;
        n_acc   = r_acc;
        n_blk   = r_blk;
        n_out   = r_out;
        case (i_cmd.op) inside
            OP_LOAD: begin
                n_total = cell_count(i_first_cell) + cell_count(i_second_cell);
                n_acc   = r_seed;
            end
            OP_BLK_LO, OP_BLK_HI, OP_ROT: n_blk = prod;
            OP_MIX: begin
                n_acc = {mix_t[18:0], mix_t[31:19]};
                n_acc = n_acc + (n_acc << 2) + MurAdd;
            end
            OP_FM1, OP_FM2: n_acc = prod;
            OP_OUT: begin
                if (r_total <= CntLinMax) begin
                    n_out = r_total[OUT_W-1:0];
                end else begin
                    n_out = {r_ex, {MANT_W{1'b0}}} + OUT_W'(r_top[MANT_W-1:0])
                          + OUT_W'(inc);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= n_total;
        r_acc   <= n_acc;
        r_blk   <= n_blk;
        r_out   <= n_out;
        // normalizer: one right shift per cycle while busy, tracking exponent and drop mask
        if (i_cmd.op == OP_LOAD) begin
            r_top  <= n_total;
            r_ex   <= EX_W'(1);
            r_mask <= '0;
        end else if (norm_busy) begin
            r_top  <= r_top >> 1;
            r_ex   <= r_ex + EX_W'(1);
            r_mask <= {r_mask[30:0], 1'b1};
        end
    end

    assign o_merged_cell = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/log_counter_merge_top.sv =====
// Top level of the log counter merge block.
// The hash takes eight steps sharing one multiplier; the normalizer shifts one bit
// a cycle while busy. A new item is taken only once the last result is registered;
// the result register frees the input side.
// Reset (i_rst_n low, synchronous): sequencer idle, no result held, seed 0.
`timescale 1ns / 1ps
`default_nettype none
module log_counter_merge_top
    import lcm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [14:0] first_cell, [29:15] second_cell
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] merged_cell
);

    t_cmd  cmd;
    t_stat stat;

    lcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    lcm_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_first_cell  (i_s_tdata[CELL_W-1:0]),
        .i_second_cell (i_s_tdata[2*CELL_W-1:CELL_W]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_merged_cell (o_m_tdata)
    );

endmodule
`default_nettype wire
